/* src/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/pidpmd_pkg.sv */
// Types and constants for the PID position motor drive.
`timescale 1ns / 1ps

package pidpmd_pkg;

  localparam int POS_W     = 32;
  localparam int ERR_W     = 33;
  localparam int DERR_W    = 34;
  localparam int SUM_W     = 48;
  localparam int GAIN_W    = 24;
  localparam int DRIVE_W   = 14;
  localparam int CMP_W     = 13;
  localparam int ACC_W     = 72;
  localparam int FRAC_BITS = 12;
  localparam int CFG_IDX_W = 8;

  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic signed [DERR_W-1:0]  derr_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [GAIN_W-1:0]  gain_t;
  typedef logic signed [DRIVE_W-1:0] drive_t;
  typedef logic [CMP_W-1:0]          cmp_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [GAIN_W-1:0]         cfg_data_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 8'd0,
    REG_INTEG_GAIN   = 8'd1,
    REG_DERIV_GAIN   = 8'd2,
    REG_DRIVE_ENABLE = 8'd3
  } cfg_reg_t;

  localparam drive_t DRIVE_MAX = 14'sd4800;
  localparam drive_t DRIVE_MIN = -14'sd4800;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

/* src/pidpmd_in_if.sv */
// Input channel: setpoint, encoder position and clear flag.
`timescale 1ns / 1ps

interface pidpmd_in_if;
  import pidpmd_pkg::*;

  logic valid;
  logic ready;
  pos_t target_position;
  pos_t measured_position;
  logic clear_errors;

  modport source (output valid, target_position, measured_position, clear_errors,
                  input ready);
  modport sink   (input valid, target_position, measured_position, clear_errors,
                  output ready);
endinterface

/* src/pidpmd_out_if.sv */
// Result channel: drive value and PWM compare values.
`timescale 1ns / 1ps

interface pidpmd_out_if;
  import pidpmd_pkg::*;

  logic   valid;
  logic   ready;
  drive_t drive_value;
  cmp_t   forward_compare;
  cmp_t   reverse_compare;
  logic   sum_saturated;

  modport source (output valid, drive_value, forward_compare, reverse_compare,
                  sum_saturated, input ready);
  modport sink   (input valid, drive_value, forward_compare, reverse_compare,
                  sum_saturated, output ready);
endinterface

/* src/pidpmd_cfg_if.sv */
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface pidpmd_cfg_if;
  import pidpmd_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/pid_position_motor_drive_top.sv */
// PID position controller with forward/reverse PWM compare outputs.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// PID position controller. Each input transfer carries a setpoint, the
// encoder position and a clear flag; each one yields exactly one result
// transfer with the clamped drive (+/-4800), forward and reverse compare
// values (zero unless drive_enable is set) and a flag telling whether the
// error sum saturated at -2^47 or 2^47-1 on that step. The block is a
// six-stage pipeline that takes one transfer per cycle unless a result
// waits; an item passes stages 1 to 5 and then the output register.
// Throughput is limited only by the result side: the whole pipeline holds
// while a result waits, and in_ch.ready follows out_ch.ready
// combinationally through the output register. The stored
// error and error sum update in stage 2, so items may follow each other
// back to back. Gains are Q12.12; the integral product is split into two
// 24x24 partial products. Configuration writes are accepted at any time but
// must only be issued while the pipeline is empty.
module pid_position_motor_drive_top (
  input  logic         clk,
  input  logic         rst_n,
  pidpmd_in_if.sink    in_ch,
  pidpmd_out_if.source out_ch,
  pidpmd_cfg_if.sink   cfg_ch
);
  import pidpmd_pkg::*;

  // Configuration registers
  gain_t kp_r, ki_r, kd_r;
  logic  enable_r;

  // Loop state
  err_t last_err_r;
  sum_t sum_r;

  // Pipeline valids
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r, out_valid_r;

  // Stage 1: error
  err_t s1_err_r;
  logic s1_clear_r;
  // Stage 2: error difference and saturated sum
  err_t  s2_err_r;
  derr_t s2_derr_r;
  sum_t  s2_sum_r;
  logic  s2_sat_r;
  // Stage 3: partial products
  logic signed [GAIN_W+ERR_W-1:0]    s3_pprop_r;
  logic signed [GAIN_W+DERR_W-1:0]   s3_pderiv_r;
  logic signed [2*GAIN_W-1:0]        s3_pihi_r;
  logic signed [2*GAIN_W:0]          s3_pilo_r;
  logic                              s3_sat_r;
  // Stage 4: integral term, and proportional + derivative
  acc_t                              s4_integ_r;
  logic signed [GAIN_W+DERR_W:0]     s4_pd_r;
  logic                              s4_sat_r;
  // Stage 5: full weighted sum
  acc_t s5_acc_r;
  logic s5_sat_r;
  // Stage 6: result register
  drive_t drive_r;
  cmp_t   fwd_r, rev_r;
  logic   sat_r;

  logic adv;
  logic in_xfer;

  // Whole pipeline moves when the result register is free or being drained.
  assign adv     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_xfer = in_ch.valid && adv;
  assign cfg_ch.ready = 1'b1;

  // ---------------- stage 1 logic ----------------
  err_t s1_err_nxt;
  assign s1_err_nxt = ERR_W'(in_ch.target_position) - ERR_W'(in_ch.measured_position);

  // ---------------- stage 2 logic ----------------
  err_t                last_eff;
  sum_t                sum_eff;
  derr_t               derr_nxt;
  logic signed [SUM_W:0] sum_wide;
  sum_t                sum_nxt;
  logic                sat_nxt;

  always_comb begin
    last_eff = s1_clear_r ? '0 : last_err_r;
    sum_eff  = s1_clear_r ? '0 : sum_r;
    derr_nxt = DERR_W'(s1_err_r) - DERR_W'(last_eff);
    sum_wide = (SUM_W+1)'(sum_eff) + (SUM_W+1)'(s1_err_r);
    sat_nxt  = sum_wide[SUM_W] != sum_wide[SUM_W-1];
    if (!sat_nxt) begin
      sum_nxt = sum_wide[SUM_W-1:0];
    end else if (sum_wide[SUM_W]) begin
      sum_nxt = SUM_MIN;
    end else begin
      sum_nxt = SUM_MAX;
    end
  end

  // ---------------- stage 3 logic ----------------
  // ki * sum splits into the signed upper half and the unsigned lower half.
  logic signed [GAIN_W+ERR_W-1:0]  pprop_nxt;
  logic signed [GAIN_W+DERR_W-1:0] pderiv_nxt;
  logic signed [2*GAIN_W-1:0]      pihi_nxt;
  logic signed [2*GAIN_W:0]        pilo_nxt;
  logic signed [GAIN_W-1:0]        sum_hi;
  logic signed [GAIN_W:0]          sum_lo;

  always_comb begin
    sum_hi     = s2_sum_r[SUM_W-1:GAIN_W];
    sum_lo     = $signed({1'b0, s2_sum_r[GAIN_W-1:0]});
    pprop_nxt  = kp_r * s2_err_r;
    pderiv_nxt = kd_r * s2_derr_r;
    pihi_nxt   = ki_r * sum_hi;
    pilo_nxt   = ki_r * sum_lo;
  end

  // ---------------- stage 4 logic ----------------
  acc_t                          integ_nxt;
  logic signed [GAIN_W+DERR_W:0] pd_nxt;

  always_comb begin
    integ_nxt = {s3_pihi_r, {GAIN_W{1'b0}}} + ACC_W'(s3_pilo_r);
    pd_nxt    = (GAIN_W+DERR_W+1)'(s3_pprop_r) + (GAIN_W+DERR_W+1)'(s3_pderiv_r);
  end

  // ---------------- stage 5 logic ----------------
  acc_t acc_nxt;
  assign acc_nxt = s4_integ_r + ACC_W'(s4_pd_r);

  // ---------------- stage 6 logic ----------------
  // Truncation toward zero: bias negative sums before the arithmetic shift.
  acc_t                             biased;
  logic signed [ACC_W-FRAC_BITS-1:0] quot;
  drive_t                           drive_nxt;
  drive_t                           drive_neg;
  cmp_t                             fwd_nxt, rev_nxt;

  always_comb begin
    biased = s5_acc_r + (s5_acc_r[ACC_W-1] ? ACC_W'({FRAC_BITS{1'b1}}) : '0);
    quot   = biased[ACC_W-1:FRAC_BITS];
    if (quot > (ACC_W-FRAC_BITS)'(DRIVE_MAX)) begin
      drive_nxt = DRIVE_MAX;
    end else if (quot < (ACC_W-FRAC_BITS)'(DRIVE_MIN)) begin
      drive_nxt = DRIVE_MIN;
    end else begin
      drive_nxt = quot[DRIVE_W-1:0];
    end
    drive_neg = -drive_nxt;
    fwd_nxt = (enable_r && !drive_nxt[DRIVE_W-1] && drive_nxt != '0) ?
              drive_nxt[CMP_W-1:0] : '0;
    rev_nxt = (enable_r && drive_nxt[DRIVE_W-1]) ? drive_neg[CMP_W-1:0] : '0;
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      enable_r    <= 1'b0;
      last_err_r  <= '0;
      sum_r       <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_PROP_GAIN:    kp_r     <= cfg_ch.data;
          REG_INTEG_GAIN:   ki_r     <= cfg_ch.data;
          REG_DERIV_GAIN:   kd_r     <= cfg_ch.data;
          REG_DRIVE_ENABLE: enable_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (adv) begin
        // loop state advances as an item enters stage 2
        if (s1_valid_r) begin
          last_err_r <= s1_err_r;
          sum_r      <= sum_nxt;
        end
        s1_valid_r  <= in_ch.valid;
        s2_valid_r  <= s1_valid_r;
        s3_valid_r  <= s2_valid_r;
        s4_valid_r  <= s3_valid_r;
        s5_valid_r  <= s4_valid_r;
        out_valid_r <= s5_valid_r;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      if (in_xfer) begin
        s1_err_r   <= s1_err_nxt;
        s1_clear_r <= in_ch.clear_errors;
      end
      s2_err_r    <= s1_err_r;
      s2_derr_r   <= derr_nxt;
      s2_sum_r    <= sum_nxt;
      s2_sat_r    <= sat_nxt;
      s3_pprop_r  <= pprop_nxt;
      s3_pderiv_r <= pderiv_nxt;
      s3_pihi_r   <= pihi_nxt;
      s3_pilo_r   <= pilo_nxt;
      s3_sat_r    <= s2_sat_r;
      s4_integ_r  <= integ_nxt;
      s4_pd_r     <= pd_nxt;
      s4_sat_r    <= s3_sat_r;
      s5_acc_r    <= acc_nxt;
      s5_sat_r    <= s4_sat_r;
      drive_r     <= drive_nxt;
      fwd_r       <= fwd_nxt;
      rev_r       <= rev_nxt;
      sat_r       <= s5_sat_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.drive_value     = drive_r;
  assign out_ch.forward_compare = fwd_r;
  assign out_ch.reverse_compare = rev_r;
  assign out_ch.sum_saturated   = sat_r;

  // ---------------- assertions ----------------
  `ASSERT_IMPL(a_drive_range, clk, rst_n, out_valid_r,
               drive_r <= DRIVE_MAX && drive_r >= DRIVE_MIN,
               "drive outside clamp range")
  `ASSERT_IMPL(a_one_side, clk, rst_n, out_valid_r,
               fwd_r == '0 || rev_r == '0,
               "forward and reverse compare both active")
  `ASSERT_IMPL(a_sat_at_limit, clk, rst_n, s2_valid_r && s2_sat_r,
               sum_r == SUM_MAX || sum_r == SUM_MIN,
               "saturation flagged but error sum not at a limit")
  `ASSERT_NEXT(a_state_tracks, clk, rst_n, adv && s1_valid_r,
               sum_r == s2_sum_r && last_err_r == s2_err_r,
               "loop state out of step with stage 2")

endmodule

/* tb/pid_position_motor_drive_top_test.sv */
// Self-checking testbench for the PID position motor drive top level.
`timescale 1ns / 1ps

// Test flow:
//   1. Hold reset, then walk a directed plan of register writes and
//      steps. Rows whose result is obvious (gains of zero or one, clamped
//      drives, truncation toward zero, disabled outputs) carry a typed-in
//      result. All other rows are checked against the predictor below.
//   2. Random phases: new gains and enable for each phase, written only once
//      the pipeline has drained. Most items track a slowly moving setpoint
//      with a small error. The rest are full-range or corner positions.
// Both sides idle at random, except in one phase where neither side idles.
// In another phase the result side holds off for a long stretch so the
// pipeline backs up into the input channel.
module pid_position_motor_drive_top_test;
  import pidpmd_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 6;
  localparam int IDLE_PCT      = 21;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 96;
  localparam int HOLD_PHASE    = 3;
  localparam int GAPLESS_PHASE = 8;
  localparam int HOLD_CYCLES   = 80;
  localparam int TAIL_CYCLES   = 12;        // pipeline is six deep
  localparam int REPORT_MAX    = 10;
  localparam int ACC_BITS      = 80;        // wider than any weighted sum

  // Indexes that decode to no register.
  localparam cfg_idx_t REG_SPARE = 8'd4;
  localparam cfg_idx_t REG_TOP   = 8'hFF;

  localparam pos_t  POS_MAX  = 32'sh7FFF_FFFF;
  localparam pos_t  POS_MIN  = 32'sh8000_0000;
  localparam gain_t GAIN_MAX = 24'sh7F_FFFF;
  localparam gain_t GAIN_MIN = 24'sh80_0000;
  localparam gain_t GAIN_ONE = 24'sd4096;  // 1.0 in Q12.12

  typedef struct packed {
    drive_t drive;
    cmp_t   fwd;
    cmp_t   rev;
    logic   sat;
  } drive_result_t;

  typedef enum bit {ROW_WRITE, ROW_STEP} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    cfg_idx_t      idx;
    cfg_data_t     data;
    pos_t          tgt;
    pos_t          meas;
    logic          clr;
    bit            typed;      // want holds the result, predictor is bypassed
    drive_result_t want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  bit   no_gaps;
  int   hold_asks;
  int   fail_count;
  int   result_count;
  int   cycle_count;

  // Predictor copy of the registers and the loop state.
  gain_t kp, ki, kd;
  logic  pwm_on;
  err_t  held_error;
  sum_t  held_sum;

  drive_result_t pending_drives[$];

  pidpmd_in_if  in_ch();
  pidpmd_out_if out_ch();
  pidpmd_cfg_if cfg_ch();

  pid_position_motor_drive_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pid_position_motor_drive_top_test failed");
      $finish;
    end
  end

  // One PID step: clear, error, difference, saturating sum, weighted sum in
  // full width, truncation toward zero, clamp, then the compare split.
  function automatic drive_result_t pid_update(pos_t tgt, pos_t meas, logic clr);
    logic signed [ACC_BITS-1:0] t_w, m_w, e_w, de_w, s_w, acc, mag;
    drive_t        drv;
    drive_result_t r;
    r = '0;
    if (clr) begin
      held_error = '0;
      held_sum   = '0;
    end
    t_w  = tgt;
    m_w  = meas;
    e_w  = t_w - m_w;
    de_w = e_w - held_error;
    s_w  = held_sum + e_w;
    if (s_w > SUM_MAX) begin
      s_w   = SUM_MAX;
      r.sat = 1'b1;
    end else if (s_w < SUM_MIN) begin
      s_w   = SUM_MIN;
      r.sat = 1'b1;
    end
    held_error = e_w[ERR_W-1:0];
    held_sum   = s_w[SUM_W-1:0];

    acc = kp * e_w + ki * s_w + kd * de_w;
    mag = acc[ACC_BITS-1] ? -acc : acc;
    mag = mag >>> FRAC_BITS;
    if (mag > DRIVE_MAX) mag = DRIVE_MAX;
    drv = drive_t'(mag[DRIVE_W-1:0]);
    if (acc[ACC_BITS-1]) drv = -drv;

    r.drive = drv;
    r.fwd   = (pwm_on && drv > 0) ? cmp_t'(drv[CMP_W-1:0]) : '0;
    r.rev   = (pwm_on && drv < 0) ? cmp_t'(mag[CMP_W-1:0]) : '0;
    return r;
  endfunction

  // Plan rows.
  function automatic plan_row_t wr(cfg_idx_t idx, cfg_data_t data);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic plan_row_t st(pos_t tgt, pos_t meas, logic clr);
    plan_row_t r;
    r      = '0;
    r.kind = ROW_STEP;
    r.tgt  = tgt;
    r.meas = meas;
    r.clr  = clr;
    return r;
  endfunction

  function automatic plan_row_t stx(pos_t tgt, pos_t meas, logic clr, drive_t drv,
                                    cmp_t fwd, cmp_t rev, logic sat);
    plan_row_t r;
    r            = st(tgt, meas, clr);
    r.typed      = 1'b1;
    r.want.drive = drv;
    r.want.fwd   = fwd;
    r.want.rev   = rev;
    r.want.sat   = sat;
    return r;
  endfunction

  function automatic cfg_data_t rand_gain();
    case ($urandom_range(0, 5))
      0:       return cfg_data_t'($urandom());
      1:       return GAIN_MAX;
      2:       return GAIN_MIN;
      3:       return cfg_data_t'($urandom_range(0, 16384) - 8192);
      4:       return cfg_data_t'($urandom_range(0, 256));
      default: return '0;
    endcase
  endfunction

  function automatic pos_t corner_pos();
    case ($urandom_range(0, 4))
      0:       return POS_MAX;
      1:       return POS_MIN;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  // Register write; the predictor copy follows on the transfer.
  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_PROP_GAIN:    kp = gain_t'(data);
      REG_INTEG_GAIN:   ki = gain_t'(data);
      REG_DERIV_GAIN:   kd = gain_t'(data);
      REG_DRIVE_ENABLE: pwm_on = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Offer one step, with random gaps before it; on the transfer the
  // expected result goes into the queue.
  task automatic send_step(pos_t tgt, pos_t meas, logic clr, bit typed,
                           drive_result_t want);
    drive_result_t calc;
    @(negedge clk);
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.target_position   <= tgt;
    in_ch.measured_position <= meas;
    in_ch.clear_errors      <= clr;
    do @(posedge clk); while (!in_ch.ready);
    calc = pid_update(tgt, meas, clr);
    pending_drives.push_back(typed ? want : calc);
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
  endtask

  // Result side: random idling, plus a long hold-off counted here on request.
  initial begin
    int hold_left;
    int asks_seen;
    hold_left    = 0;
    asks_seen    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != asks_seen) begin
        asks_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Result checker: every transfer against the oldest expectation.
  always @(posedge clk) begin
    drive_result_t seen, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.drive = out_ch.drive_value;
      seen.fwd   = out_ch.forward_compare;
      seen.rev   = out_ch.reverse_compare;
      seen.sat   = out_ch.sum_saturated;
      result_count++;
      if (pending_drives.size() == 0) begin
        if (fail_count < REPORT_MAX)
          $display("%0t: result %0d arrived with nothing outstanding", $realtime,
                   result_count);
        fail_count++;
      end else begin
        want = pending_drives.pop_front();
        if (seen.drive !== want.drive || seen.fwd !== want.fwd ||
            seen.rev !== want.rev || seen.sat !== want.sat) begin
          if (fail_count < REPORT_MAX)
            $display({"%0t: result %0d mismatch: drive exp %0d got %0d, ",
                      "fwd exp %0d got %0d, rev exp %0d got %0d, sat exp %0b got %0b"},
                     $realtime, result_count, want.drive, seen.drive, want.fwd,
                     seen.fwd, want.rev, seen.rev, want.sat, seen.sat);
          fail_count++;
        end
      end
    end
  end

  initial begin
    plan_row_t plan[$];
    pos_t      tgt, meas, walk;
    logic      clr;
    int        pick;

    in_ch.valid             = 1'b0;
    in_ch.target_position   = '0;
    in_ch.measured_position = '0;
    in_ch.clear_errors      = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = '0;
    cfg_ch.data             = '0;
    rst_n                   = 1'b0;
    no_gaps                 = 1'b0;
    hold_asks               = 0;
    fail_count              = 0;
    result_count            = 0;
    cycle_count             = 0;
    kp                      = '0;
    ki                      = '0;
    kd                      = '0;
    pwm_on                  = 1'b0;
    held_error              = '0;
    held_sum                = '0;
    walk                    = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    plan = '{
      // gains at reset are zero, so full-scale error gives no drive
      stx(POS_MAX, POS_MIN, 1'b0, 0, 0, 0, 1'b0),
      wr(REG_PROP_GAIN, GAIN_ONE),
      wr(REG_DRIVE_ENABLE, 24'd1),
      stx(100, 0, 1'b1, 100, 100, 0, 1'b0),
      stx(0, 100, 1'b1, -100, 0, 100, 1'b0),
      // clamp both ways
      stx(POS_MAX, POS_MIN, 1'b0, DRIVE_MAX, 4800, 0, 1'b0),
      stx(POS_MIN, POS_MAX, 1'b0, DRIVE_MIN, 0, 4800, 1'b0),
      // zero error, zero drive
      stx(12345, 12345, 1'b0, 0, 0, 0, 1'b0),
      // enable takes bit 0 only: this write disables the outputs
      wr(REG_DRIVE_ENABLE, 24'hFF_FFFE),
      stx(100, 0, 1'b1, 100, 0, 0, 1'b0),
      // writes to undecoded indexes must not land anywhere
      wr(REG_SPARE, 24'hFF_FFFF),
      wr(REG_TOP, 24'h00_0001),
      stx(0, 100, 1'b0, -100, 0, 0, 1'b0),
      // smallest gain: truncation toward zero
      wr(REG_PROP_GAIN, 24'd1),
      wr(REG_DRIVE_ENABLE, 24'd1),
      stx(0, 4097, 1'b0, -1, 0, 1, 1'b0),
      stx(4095, 0, 1'b0, 0, 0, 0, 1'b0),
      // derivative only, with and without clear
      wr(REG_PROP_GAIN, 24'd0),
      wr(REG_DERIV_GAIN, GAIN_ONE),
      stx(10, 0, 1'b1, 10, 10, 0, 1'b0),
      stx(3, 0, 1'b0, -7, 0, 7, 1'b0),
      stx(3, 0, 1'b1, 3, 3, 0, 1'b0),
      // extreme gains, both sign patterns
      wr(REG_PROP_GAIN, GAIN_MIN),
      wr(REG_INTEG_GAIN, GAIN_MAX),
      wr(REG_DERIV_GAIN, GAIN_MIN),
      st(POS_MAX, POS_MIN, 1'b0),
      st(POS_MIN, POS_MAX, 1'b0),
      st(0, 0, 1'b1),
      st(-5, 7, 1'b0),
      wr(REG_PROP_GAIN, GAIN_MAX),
      wr(REG_INTEG_GAIN, GAIN_MIN),
      wr(REG_DERIV_GAIN, GAIN_MAX),
      st(1000, -1000, 1'b0),
      st(POS_MIN, POS_MAX, 1'b1),
      st(123456, -7, 1'b0)
    };

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_step(plan[i].tgt, plan[i].meas, plan[i].clr, plan[i].typed, plan[i].want);
      end
    end

    // Random phases. Registers change only with the pipeline empty.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      write_reg(REG_PROP_GAIN, rand_gain());
      write_reg(REG_INTEG_GAIN, rand_gain());
      write_reg(REG_DERIV_GAIN, rand_gain());
      write_reg(REG_DRIVE_ENABLE, cfg_data_t'($urandom()));
      // one phase runs back to back on both sides
      no_gaps = (ph == GAPLESS_PHASE);
      // long result-side stall while the sender keeps offering
      if (ph == HOLD_PHASE) hold_asks++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // tracking: setpoint wanders, position stays close behind
          walk = walk + pos_t'($urandom_range(0, 2000)) - 1000;
          tgt  = walk;
          meas = walk + pos_t'($urandom_range(0, 4000)) - 2000;
        end else if (pick < 90) begin
          tgt  = pos_t'($urandom());
          meas = pos_t'($urandom());
        end else begin
          tgt  = corner_pos();
          meas = corner_pos();
        end
        clr = ($urandom_range(0, 99) < 4);
        send_step(tgt, meas, clr, 1'b0, '0);
      end
    end

    drain_results();
    no_gaps = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("pid_position_motor_drive_top_test passed");
    end else begin
      $display("pid_position_motor_drive_top_test failed");
    end
    $finish;
  end

endmodule
